>>> design/pdlq_pkg.sv
// Shared types, codes and defaults for the paced dedup LIFO queue.
package pdlq_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_HANDLE_BITS = 16;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_LIMIT  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEND_SPACING = 4'd1;

  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_CLOSE   = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_START   = 3'd4;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_SENT      = 3'd2;
  localparam logic [2:0] ST_DISCARDED = 3'd3;
  localparam logic [2:0] ST_HELD      = 3'd4;
  localparam logic [2:0] ST_CLOSED    = 3'd5;
  localparam logic [2:0] ST_NONE      = 3'd6;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] req_handle;
    logic [31:0] now_seconds;
    logic        gate_open;
    logic        top_allowed;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [6:0]  evicted_count;
    logic [6:0]  entry_count_out;
    logic        top_valid;
    logic [15:0] top_handle;
    logic [31:0] sent_total_out;
    logic [31:0] dropped_total_out;
  } out_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic cap;    // capture match against the key
    logic evict;  // every cell takes its upper neighbor
    logic del;    // cells at or above the match take their upper neighbor
    logic push;   // the cell at the fill level takes the key
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

>>> design/pdlq_cell.sv
// One stack cell: holds a handle, compares it to the key, shifts down on command.
module pdlq_cell
  import pdlq_pkg::*;
#(
  parameter int HANDLE_BITS = DEF_HANDLE_BITS,
  parameter int CW          = 7,
  parameter int CELL_IDX    = 0
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [CW-1:0]          count,
  input  logic [HANDLE_BITS-1:0] key,
  input  logic [HANDLE_BITS-1:0] up_data,
  input  logic                   ge_bit,
  output logic [HANDLE_BITS-1:0] data,
  output logic                   match,
  output logic [HANDLE_BITS-1:0] top_part
);

  logic [HANDLE_BITS-1:0] data_r, data_nxt;
  logic                   match_r, match_nxt;
  logic                   occ;
  logic                   is_top;

  assign occ    = CW'(CELL_IDX) < count;
  assign is_top = count == CW'(CELL_IDX + 1);

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    if (ctl.cap) begin
      match_nxt = occ && (data_r == key);
    end
    if (ctl.evict || (ctl.del && ge_bit)) begin
      data_nxt = up_data;
    end else if (ctl.push && (count == CW'(CELL_IDX))) begin
      data_nxt = key;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data     = data_r;
  assign match    = match_r;
  assign top_part = is_top ? data_r : '0;

endmodule

>>> design/pdlq_ctrl.sv
// Sequencer, counters, configuration registers and result register of the queue.
module pdlq_ctrl
  import pdlq_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS,
  parameter int CW          = $clog2(STACK_DEPTH + 2)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [STACK_DEPTH-1:0] match_vec,
  input  logic [HANDLE_BITS-1:0] top_comb,
  output cell_ctl_t              ctl,
  output logic [CW-1:0]          count,
  output logic [HANDLE_BITS-1:0] key,
  output logic [STACK_DEPTH-1:0] ge_mask
);

  localparam int EW = (CW > 7) ? CW : 7;

  state_t                 state_r, state_nxt;
  in_t                    item_r, item_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [31:0]            last_r, last_nxt;
  logic [31:0]            sent_r, sent_nxt;
  logic [31:0]            dropped_r, dropped_nxt;
  logic [6:0]             limit_r, limit_nxt;
  logic [15:0]            spacing_r, spacing_nxt;
  logic [CW-1:0]          ev_r, ev_nxt;
  logic                   push_r, push_nxt;
  logic [6:0]             evicted_r, evicted_nxt;
  logic [2:0]             status_r, status_nxt;
  logic [HANDLE_BITS-1:0] oh_r, oh_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;

  logic                   accept;
  logic                   found;
  logic [31:0]            in_h32, item_h32;
  logic [EW-1:0]          limit_ext, lim, n_ext, e_full, count_ext;
  logic [CW-1:0]          e_old;
  logic [31:0]            elapsed;
  logic                   spacing_ok;
  logic [31:0]            oh_ext;
  logic [31:0]            top_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign in_h32   = 32'(in_data.req_handle);
  assign item_h32 = 32'(item_r.req_handle);
  assign key      = (state_r == S_IDLE) ? in_h32[HANDLE_BITS-1:0] : item_h32[HANDLE_BITS-1:0];

  // Handles in the stack are unique, so at most one match bit is set.
  assign found   = |match_vec;
  assign ge_mask = found ? ~(match_vec - STACK_DEPTH'(1)) : '0;

  // Eviction arithmetic for a non-duplicate enqueue.
  assign limit_ext = EW'(limit_r);
  assign lim       = (limit_ext > EW'(STACK_DEPTH)) ? EW'(STACK_DEPTH) : limit_ext;
  assign count_ext = EW'(count_r);
  assign n_ext     = count_ext + EW'(1);
  assign e_full    = (n_ext > lim) ? (n_ext - lim) : '0;
  assign e_old     = (e_full < count_ext) ? e_full[CW-1:0] : count_r;

  assign elapsed    = item_r.now_seconds - last_r;
  assign spacing_ok = !elapsed[31] && (elapsed >= 32'(spacing_r));

  assign oh_ext  = 32'(oh_r);
  assign top_ext = 32'(top_comb);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    sent_nxt      = sent_r;
    dropped_nxt   = dropped_r;
    limit_nxt     = limit_r;
    spacing_nxt   = spacing_r;
    ev_nxt        = ev_r;
    push_nxt      = push_r;
    evicted_nxt   = evicted_r;
    status_nxt    = status_r;
    oh_nxt        = oh_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    ctl           = '0;
    ctl.cap       = accept;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_QUEUE_LIMIT:  limit_nxt   = cfg_wdata[6:0];
        CFG_SEND_SPACING: spacing_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          status_nxt  = ST_NONE;
          oh_nxt      = '0;
          evicted_nxt = '0;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_FINISH;
        case (item_r.opcode)
          OP_ENQUEUE: begin
            if (found) begin
              status_nxt = ST_DUPLICATE;
            end else begin
              status_nxt  = ST_QUEUED;
              ev_nxt      = e_old;
              push_nxt    = e_full <= count_ext;
              evicted_nxt = e_full[6:0];
              dropped_nxt = dropped_r + 32'(e_full);
              state_nxt   = S_SHIFT;
            end
          end
          OP_TICK: begin
            if (count_r == '0) begin
              status_nxt = ST_NONE;
            end else if (!spacing_ok || !item_r.gate_open) begin
              status_nxt = ST_HELD;
            end else begin
              oh_nxt    = top_comb;
              count_nxt = count_r - CW'(1);
              if (item_r.top_allowed) begin
                sent_nxt   = sent_r + 32'd1;
                last_nxt   = item_r.now_seconds;
                status_nxt = ST_SENT;
              end else begin
                status_nxt = ST_DISCARDED;
              end
            end
          end
          OP_CLOSE: begin
            if (found) begin
              ctl.del    = 1'b1;
              count_nxt  = count_r - CW'(1);
              status_nxt = ST_CLOSED;
              oh_nxt     = key;
            end
          end
          OP_CLEAR: begin
            count_nxt = '0;
          end
          OP_START: begin
            count_nxt = '0;
            last_nxt  = item_r.now_seconds;
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        if (ev_r != '0) begin
          ctl.evict = 1'b1;
          count_nxt = count_r - CW'(1);
          ev_nxt    = ev_r - CW'(1);
        end else begin
          if (push_r && (count_r < CW'(STACK_DEPTH))) begin
            ctl.push  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.status            = status_r;
          out_data_nxt.out_handle        = oh_ext[15:0];
          out_data_nxt.evicted_count     = evicted_r;
          out_data_nxt.entry_count_out   = count_ext[6:0];
          out_data_nxt.top_valid         = count_r != '0;
          out_data_nxt.top_handle        = (count_r != '0) ? top_ext[15:0] : 16'd0;
          out_data_nxt.sent_total_out    = sent_r;
          out_data_nxt.dropped_total_out = dropped_r;
          state_nxt                      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      last_r      <= '0;
      sent_r      <= '0;
      dropped_r   <= '0;
      limit_r     <= 7'd64;
      spacing_r   <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      sent_r      <= sent_nxt;
      dropped_r   <= dropped_nxt;
      limit_r     <= limit_nxt;
      spacing_r   <= spacing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ev_r       <= ev_nxt;
    push_r     <= push_nxt;
    evicted_r  <= evicted_nxt;
    status_r   <= status_nxt;
    oh_r       <= oh_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign count     = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> $onehot0(match_vec))
    else $error("handle held in more than one cell");

  a_evict_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && ev_r != '0) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("eviction step did not drop one entry");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result loaded outside the finish step");

endmodule

>>> design/paced_dedup_lifo_queue_core.sv
// Top level of the paced dedup LIFO queue: sequencer plus a row of stack cells.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command per
//   transfer: enqueue, process tick, close, clear or start. Each command yields
//   exactly one result on the output channel (out_valid / out_stall / out_data).
//   The configuration port (cfg_wr_en / cfg_index / cfg_wdata) sets the queue
//   limit (index 0) and the send spacing in seconds (index 1); write it only
//   while no command is in flight.
// Sequence:
//   The cells capture their match bits at the accepting edge. A decide step,
//   then for an enqueue that is not a duplicate one eviction step per evicted
//   older entry plus one push step, then a finish step that loads the result
//   register. Tick, close, clear, start and a duplicate enqueue go from the
//   decide step straight to the finish step. The next command is taken in the
//   cycle after the result loads, not while another command is in its steps.
//   Eviction shifts the cell row by one position per cycle.
// Reset: the stack empties, counters and last-send time clear, the limit
//   returns to 64 and the spacing to 1. Cell contents are not cleared.
// Stall: a result waits in the output register while out_stall is high; the
//   next command may be taken meanwhile and holds in its finish cycle.
module paced_dedup_lifo_queue_core
  import pdlq_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Count holds 0..STACK_DEPTH and the eviction figure up to STACK_DEPTH + 1.
  localparam int CW = $clog2(STACK_DEPTH + 2);

  cell_ctl_t              ctl;
  logic [CW-1:0]          count;
  logic [HANDLE_BITS-1:0] key;
  logic [STACK_DEPTH-1:0] ge_mask;
  logic [STACK_DEPTH-1:0] match_vec;
  logic [HANDLE_BITS-1:0] top_comb;
  logic [HANDLE_BITS-1:0] cell_data [STACK_DEPTH];
  logic [HANDLE_BITS-1:0] top_part  [STACK_DEPTH];

  pdlq_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .match_vec (match_vec),
    .top_comb  (top_comb),
    .ctl       (ctl),
    .count     (count),
    .key       (key),
    .ge_mask   (ge_mask)
  );

  // Cell 0 holds the oldest entry; each cell but the last pulls from the one above it.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] up_data;
    if (i == STACK_DEPTH - 1) begin : g_last
      assign up_data = cell_data[i];
    end else begin : g_mid
      assign up_data = cell_data[i+1];
    end

    pdlq_cell #(
      .HANDLE_BITS (HANDLE_BITS),
      .CW          (CW),
      .CELL_IDX    (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count),
      .key      (key),
      .up_data  (up_data),
      .ge_bit   (ge_mask[i]),
      .data     (cell_data[i]),
      .match    (match_vec[i]),
      .top_part (top_part[i])
    );
  end

  // Only the cell just below the fill level drives a nonzero top part.
  always_comb begin
    top_comb = '0;
    for (int k = 0; k < STACK_DEPTH; k++) begin
      top_comb = top_comb | top_part[k];
    end
  end

endmodule
